// File: rtl/fsic_pkg.sv
// Shared constants, types and saturation helpers for the flywheel speed controller.
`timescale 1ns / 1ps

package fsic_pkg;

    // Serial arithmetic unit widths
    localparam int unsigned MUL_W = 84;     // multiplicand and product
    localparam int unsigned MPL_W = 32;     // multiplier
    localparam int unsigned DVD_W = 84;     // dividend
    localparam int unsigned DVS_W = 36;     // divisor
    localparam int unsigned QUO_W = 32;     // kept quotient bits
    localparam int unsigned CNT_W = 7;      // step count

    // Configuration port
    localparam int unsigned ADDR_W = 5;
    localparam logic [2:0] REG_GAIN      = 3'd0;
    localparam logic [2:0] REG_GEAR      = 3'd1;
    localparam logic [2:0] REG_TICKS     = 3'd2;
    localparam logic [2:0] REG_SMOOTH    = 3'd3;
    localparam logic [2:0] REG_ERR_WIN   = 3'd4;
    localparam logic [2:0] REG_SLOPE_WIN = 3'd5;

    // Input commands
    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_SET    = 1'b1;

    localparam logic [19:0] US_PER_S       = 20'd1000000;
    localparam logic [15:0] TICKS_RESET    = 16'd360;
    localparam logic [23:0] SMOOTH_RESET   = 24'd100000;
    localparam logic [31:0] S32_MAX        = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN        = 32'h8000_0000;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] len;
    } t_unit_cmd;

    // Clamp a 34-bit signed value to the signed 32-bit range.
    function automatic logic [31:0] sat34(input logic [33:0] v);
        logic [31:0] r;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
            r = v[31:0];
        end else if (v[33]) begin
            r = S32_MIN;
        end else begin
            r = S32_MAX;
        end
        return r;
    endfunction

    // Signed, saturated value from a sign and a quotient magnitude.
    function automatic logic [31:0] sat_mag(input logic neg, input logic ovf,
                                            input logic [31:0] mag);
        logic [31:0] r;
        if (!neg) begin
            r = (ovf || mag[31]) ? S32_MAX : mag;
        end else if (ovf || (mag[31] && (mag[30:0] != 31'd0))) begin
            r = S32_MIN;
        end else begin
            r = ~mag + 32'd1;
        end
        return r;
    endfunction

    // Saturating base plus or minus a quotient magnitude.
    function automatic logic [31:0] acc_sat(input logic [31:0] base, input logic neg,
                                            input logic ovf, input logic [31:0] mag);
        logic [33:0] a;
        logic [33:0] b;
        logic [31:0] r;
        a = {{2{base[31]}}, base};
        b = {2'b00, mag};
        if (ovf) begin
            r = neg ? S32_MIN : S32_MAX;
        end else begin
            r = sat34(neg ? (a - b) : (a + b));
        end
        return r;
    endfunction

endpackage

// File: rtl/fsic_if.sv
// Valid/ready channel interfaces for controller items and results.
`timescale 1ns / 1ps

interface fsic_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic signed [31:0] encoder_count;
    logic [19:0]        elapsed_us;
    logic signed [31:0] target_speed;

    modport source (output valid, command, encoder_count, elapsed_us, target_speed,
                    input ready);
    modport sink (input valid, command, encoder_count, elapsed_us, target_speed,
                  output ready);
endinterface

interface fsic_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] drive_action;
    logic signed [31:0] filtered_speed;
    logic signed [31:0] speed_error;
    logic               ready_mode;

    modport source (output valid, drive_action, filtered_speed, speed_error, ready_mode,
                    input ready);
    modport sink (input valid, drive_action, filtered_speed, speed_error, ready_mode,
                  output ready);
endinterface

// File: rtl/fsic_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps

module fsic_mul (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  fsic_pkg::t_unit_cmd        i_cmd,
    input  logic [fsic_pkg::MUL_W-1:0] i_mcand,
    input  logic [fsic_pkg::MPL_W-1:0] i_mplier,
    output logic                       o_done,
    output logic [fsic_pkg::MUL_W-1:0] o_prod
);

    logic [fsic_pkg::MUL_W-1:0] r_acc;
    logic [fsic_pkg::MUL_W-1:0] r_mc;
    logic [fsic_pkg::MPL_W-1:0] r_mp;
    logic [fsic_pkg::CNT_W-1:0] r_cnt;
    logic                       r_busy;
    logic                       r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_acc  <= '0;
                r_mc   <= i_mcand;
                r_mp   <= i_mplier;
                r_cnt  <= i_cmd.len;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_mp[0]) begin
                    r_acc <= r_acc + r_mc;
                end
                r_mc  <= r_mc << 1;
                r_mp  <= r_mp >> 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == fsic_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// File: rtl/fsic_div.sv
// Restoring bit-serial divider, one quotient bit per cycle, flagging quotient overflow.
`timescale 1ns / 1ps

module fsic_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  fsic_pkg::t_unit_cmd        i_cmd,
    input  logic [fsic_pkg::DVD_W-1:0] i_dividend,
    input  logic [fsic_pkg::DVS_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [fsic_pkg::QUO_W-1:0] o_quo,
    output logic                       o_ovf
);

    logic [fsic_pkg::DVD_W-1:0] r_num;
    logic [fsic_pkg::DVS_W-1:0] r_dvs;
    logic [fsic_pkg::DVS_W-1:0] r_rem;
    logic [fsic_pkg::QUO_W-1:0] r_quo;
    logic                       r_ovf;
    logic [fsic_pkg::CNT_W-1:0] r_cnt;
    logic                       r_busy;
    logic                       r_done;

    logic [fsic_pkg::DVS_W:0]   n_trial;
    logic                       n_ge;
    logic [fsic_pkg::DVS_W:0]   n_rem;

    always_comb begin
        n_trial = {r_rem, r_num[fsic_pkg::DVD_W-1]};
        n_ge    = (n_trial >= {1'b0, r_dvs});
        n_rem   = n_ge ? (n_trial - {1'b0, r_dvs}) : n_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_num  <= i_dividend;
                r_dvs  <= i_divisor;
                r_rem  <= '0;
                r_quo  <= '0;
                r_ovf  <= 1'b0;
                r_cnt  <= i_cmd.len;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // remainder stays below the divisor, so its top trial bit drops
                r_rem <= n_rem[fsic_pkg::DVS_W-1:0];
                r_quo <= {r_quo[fsic_pkg::QUO_W-2:0], n_ge};
                r_ovf <= r_ovf | r_quo[fsic_pkg::QUO_W-1];
                r_num <= r_num << 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == fsic_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_ovf  = r_ovf;

endmodule

// File: rtl/flywheel_speed_integral_controller_core.sv
// Top level of the flywheel speed controller: sequencer, state, config port.
`timescale 1ns / 1ps
// An update item runs on one serial multiplier and one serial divider, one bit
// per cycle, shared by seven products and four quotients; a set-target item or
// an update with zero elapsed time skips the arithmetic and goes straight to
// the result register. One item is in flight at a time.
// Reset (synchronous, active low) restores the config registers and clears the
// controller state, with ready mode set; no clearing pass is needed.

module flywheel_speed_integral_controller_core #(
    parameter int unsigned CHECK_PERIOD = 20,
    parameter int unsigned FRAC_BITS    = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    fsic_in_if.sink                     i_in,
    fsic_out_if.source                  o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fsic_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam logic [31:0] ONE_Q   = 32'd1 << FRAC_BITS;
    localparam logic [9:0]  CHK_END = 10'(CHECK_PERIOD);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_DEN, S_MUL_A, S_MUL_N, S_DIV_RAW, S_MUL_SLOPE, S_DIV_SLOPE,
        S_MUL_EST, S_DIV_EST, S_ERR, S_MUL_P, S_MUL_PDT, S_DIV_DRV, S_DONE
    } t_state;

    // Configuration registers
    logic [31:0] r_gain;
    logic [31:0] r_gear;
    logic [15:0] r_ticks;
    logic [23:0] r_smooth;
    logic [30:0] r_err_win;
    logic [30:0] r_slope_win;

    // Controller state
    logic [31:0] r_last_count;
    logic [31:0] r_est;
    logic [31:0] r_slope;
    logic [31:0] r_err;
    logic [31:0] r_drive;
    logic [31:0] r_target;
    logic        r_ready;
    logic [9:0]  r_chk;

    // Working registers for one update
    t_state      r_state;
    logic        r_go;
    logic [31:0] r_count;
    logic [19:0] r_dt;
    logic        r_dneg;
    logic [31:0] r_dmag;
    logic [35:0] r_den;
    logic [63:0] r_a;
    logic        r_dfneg;
    logic [31:0] r_dfmag;
    logic        r_pneg;
    logic [63:0] r_pmag;

    // Result register
    logic        r_out_valid;
    logic [31:0] r_out_drive;
    logic [31:0] r_out_speed;
    logic [31:0] r_out_error;
    logic        r_out_mode;

    // Shared serial units
    fsic_pkg::t_unit_cmd        mul_cmd;
    logic [fsic_pkg::MUL_W-1:0] mul_mcand;
    logic [fsic_pkg::MPL_W-1:0] mul_mplier;
    logic                       mul_done;
    logic [fsic_pkg::MUL_W-1:0] mul_prod;
    fsic_pkg::t_unit_cmd        div_cmd;
    logic [fsic_pkg::DVD_W-1:0] div_dividend;
    logic [fsic_pkg::DVS_W-1:0] div_divisor;
    logic                       div_done;
    logic [fsic_pkg::QUO_W-1:0] div_quo;
    logic                       div_ovf;

    // Combinational next values
    logic [31:0] n_delta;
    logic [31:0] n_dmag;
    logic [15:0] n_ticks_eff;
    logic [23:0] n_smooth_eff;
    logic [31:0] n_raw;
    logic [33:0] n_diff;
    logic [33:0] n_diff_mag;
    logic [31:0] n_gain_mag;
    logic [31:0] n_err_mag;
    logic [31:0] n_slope_mag;
    logic [9:0]  n_chk;

    always_comb begin
        n_delta      = i_in.encoder_count - r_last_count;
        n_dmag       = n_delta[31] ? (~n_delta + 32'd1) : n_delta;
        n_ticks_eff  = (r_ticks == 16'd0) ? 16'd1 : r_ticks;
        n_smooth_eff = (r_smooth == 24'd0) ? 24'd1 : r_smooth;
        n_raw        = fsic_pkg::sat_mag(r_dneg, div_ovf, div_quo);
        n_diff       = {{2{n_raw[31]}}, n_raw} - {{2{r_est[31]}}, r_est};
        n_diff_mag   = n_diff[33] ? (~n_diff + 34'd1) : n_diff;
        n_gain_mag   = r_gain[31] ? (~r_gain + 32'd1) : r_gain;
        n_err_mag    = r_err[31] ? (~r_err + 32'd1) : r_err;
        n_slope_mag  = r_slope[31] ? (~r_slope + 32'd1) : r_slope;
        n_chk        = r_chk + 10'd1;
    end

    // Operand selection for the shared units; start on the first cycle of a step
    always_comb begin
        mul_mcand    = '0;
        mul_mplier   = '0;
        mul_cmd      = '0;
        div_dividend = '0;
        div_divisor  = '0;
        div_cmd      = '0;
        case (r_state)
            S_MUL_DEN: begin
                mul_mcand  = fsic_pkg::MUL_W'(n_ticks_eff);
                mul_mplier = fsic_pkg::MPL_W'(r_dt);
                mul_cmd    = '{start: r_go, len: fsic_pkg::CNT_W'(20)};
            end
            S_MUL_A: begin
                mul_mcand  = fsic_pkg::MUL_W'(r_gear);
                mul_mplier = r_dmag;
                mul_cmd    = '{start: r_go, len: fsic_pkg::CNT_W'(32)};
            end
            S_MUL_N: begin
                mul_mcand  = fsic_pkg::MUL_W'(r_a);
                mul_mplier = fsic_pkg::MPL_W'(fsic_pkg::US_PER_S);
                mul_cmd    = '{start: r_go, len: fsic_pkg::CNT_W'(20)};
            end
            S_DIV_RAW: begin
                div_dividend = mul_prod;
                div_divisor  = r_den;
                div_cmd      = '{start: r_go, len: fsic_pkg::CNT_W'(fsic_pkg::DVD_W)};
            end
            S_MUL_SLOPE: begin
                mul_mcand  = fsic_pkg::MUL_W'(r_dfmag);
                mul_mplier = fsic_pkg::MPL_W'(fsic_pkg::US_PER_S);
                mul_cmd    = '{start: r_go, len: fsic_pkg::CNT_W'(20)};
            end
            S_MUL_EST: begin
                mul_mcand  = fsic_pkg::MUL_W'(r_dfmag);
                mul_mplier = fsic_pkg::MPL_W'(r_dt);
                mul_cmd    = '{start: r_go, len: fsic_pkg::CNT_W'(20)};
            end
            S_DIV_SLOPE, S_DIV_EST: begin
                // product stays below 2^52: shift only its low 52 bits through
                div_dividend = {mul_prod[51:0], 32'd0};
                div_divisor  = fsic_pkg::DVS_W'(n_smooth_eff);
                div_cmd      = '{start: r_go, len: fsic_pkg::CNT_W'(52)};
            end
            S_MUL_P: begin
                mul_mcand  = fsic_pkg::MUL_W'(n_gain_mag);
                mul_mplier = n_err_mag;
                mul_cmd    = '{start: r_go, len: fsic_pkg::CNT_W'(32)};
            end
            S_MUL_PDT: begin
                mul_mcand  = fsic_pkg::MUL_W'(r_pmag);
                mul_mplier = fsic_pkg::MPL_W'(r_dt);
                mul_cmd    = '{start: r_go, len: fsic_pkg::CNT_W'(20)};
            end
            S_DIV_DRV: begin
                // drop the fraction bits by not shifting them in
                div_dividend = {mul_prod[fsic_pkg::DVD_W-1:FRAC_BITS], {FRAC_BITS{1'b0}}};
                div_divisor  = fsic_pkg::DVS_W'(fsic_pkg::US_PER_S);
                div_cmd      = '{start: r_go,
                                 len: fsic_pkg::CNT_W'(fsic_pkg::DVD_W - FRAC_BITS)};
            end
            default: ;
        endcase
    end

    fsic_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (mul_cmd),
        .i_mcand  (mul_mcand),
        .i_mplier (mul_mplier),
        .o_done   (mul_done),
        .o_prod   (mul_prod)
    );

    fsic_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (div_cmd),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_ovf      (div_ovf)
    );

    // Configuration writes; the host is to write only while no item is in flight (the block does not enforce it)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain      <= ONE_Q;
            r_gear      <= ONE_Q;
            r_ticks     <= fsic_pkg::TICKS_RESET;
            r_smooth    <= fsic_pkg::SMOOTH_RESET;
            r_err_win   <= ONE_Q[30:0];
            r_slope_win <= ONE_Q[30:0];
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
                fsic_pkg::REG_GAIN:      r_gain      <= pwdata;
                fsic_pkg::REG_GEAR:      r_gear      <= pwdata;
                fsic_pkg::REG_TICKS:     r_ticks     <= pwdata[15:0];
                fsic_pkg::REG_SMOOTH:    r_smooth    <= pwdata[23:0];
                fsic_pkg::REG_ERR_WIN:   r_err_win   <= pwdata[30:0];
                fsic_pkg::REG_SLOPE_WIN: r_slope_win <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            fsic_pkg::REG_GAIN:      prdata = r_gain;
            fsic_pkg::REG_GEAR:      prdata = r_gear;
            fsic_pkg::REG_TICKS:     prdata = {16'd0, r_ticks};
            fsic_pkg::REG_SMOOTH:    prdata = {8'd0, r_smooth};
            fsic_pkg::REG_ERR_WIN:   prdata = {1'b0, r_err_win};
            fsic_pkg::REG_SLOPE_WIN: prdata = {1'b0, r_slope_win};
            default:                 prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Sequencer: each arithmetic step starts its unit, then waits for done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_go         <= 1'b0;
            r_out_valid  <= 1'b0;
            r_last_count <= '0;
            r_est        <= '0;
            r_slope      <= '0;
            r_err        <= '0;
            r_drive      <= '0;
            r_target     <= '0;
            r_ready      <= 1'b1;
            r_chk        <= '0;
        end else begin
            // drop the result once the sink takes it, unless a new one loads
            if (r_out_valid && o_out.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        if (i_in.command == fsic_pkg::CMD_SET) begin
                            r_target <= i_in.target_speed;
                            r_ready  <= 1'b0;
                            r_state  <= S_DONE;
                        end else if (i_in.elapsed_us == 20'd0) begin
                            // no time has passed: leave everything alone
                            r_state <= S_DONE;
                        end else begin
                            r_count <= i_in.encoder_count;
                            r_dt    <= i_in.elapsed_us;
                            r_dneg  <= n_delta[31];
                            r_dmag  <= n_dmag;
                            r_go    <= 1'b1;
                            r_state <= S_MUL_DEN;
                        end
                    end
                end
                S_MUL_DEN: begin
                    if (r_go) begin
                        r_go <= 1'b0;
                    end else if (mul_done) begin
                        r_den   <= mul_prod[35:0];
                        r_go    <= 1'b1;
                        r_state <= S_MUL_A;
                    end
                end
                S_MUL_A: begin
                    if (r_go) begin
                        r_go <= 1'b0;
                    end else if (mul_done) begin
                        r_a     <= mul_prod[63:0];
                        r_go    <= 1'b1;
                        r_state <= S_MUL_N;
                    end
                end
                S_MUL_N: begin
                    if (r_go) begin
                        r_go <= 1'b0;
                    end else if (mul_done) begin
                        r_go    <= 1'b1;
                        r_state <= S_DIV_RAW;
                    end
                end
                S_DIV_RAW: begin
                    if (r_go) begin
                        r_go <= 1'b0;
                    end else if (div_done) begin
                        // raw speed minus the old estimate
                        r_dfneg <= n_diff[33];
                        r_dfmag <= n_diff_mag[31:0];
                        r_go    <= 1'b1;
                        r_state <= S_MUL_SLOPE;
                    end
                end
                S_MUL_SLOPE: begin
                    if (r_go) begin
                        r_go <= 1'b0;
                    end else if (mul_done) begin
                        r_go    <= 1'b1;
                        r_state <= S_DIV_SLOPE;
                    end
                end
                S_DIV_SLOPE: begin
                    if (r_go) begin
                        r_go <= 1'b0;
                    end else if (div_done) begin
                        r_slope <= fsic_pkg::sat_mag(r_dfneg, div_ovf, div_quo);
                        r_go    <= 1'b1;
                        r_state <= S_MUL_EST;
                    end
                end
                S_MUL_EST: begin
                    if (r_go) begin
                        r_go <= 1'b0;
                    end else if (mul_done) begin
                        r_go    <= 1'b1;
                        r_state <= S_DIV_EST;
                    end
                end
                S_DIV_EST: begin
                    if (r_go) begin
                        r_go <= 1'b0;
                    end else if (div_done) begin
                        r_est   <= fsic_pkg::acc_sat(r_est, r_dfneg, div_ovf, div_quo);
                        r_state <= S_ERR;
                    end
                end
                S_ERR: begin
                    r_err   <= fsic_pkg::sat34({{2{r_est[31]}}, r_est} -
                                               {{2{r_target[31]}}, r_target});
                    r_go    <= 1'b1;
                    r_state <= S_MUL_P;
                end
                S_MUL_P: begin
                    if (r_go) begin
                        r_go <= 1'b0;
                    end else if (mul_done) begin
                        r_pneg  <= r_gain[31] ^ r_err[31];
                        r_pmag  <= mul_prod[63:0];
                        r_go    <= 1'b1;
                        r_state <= S_MUL_PDT;
                    end
                end
                S_MUL_PDT: begin
                    if (r_go) begin
                        r_go <= 1'b0;
                    end else if (mul_done) begin
                        r_go    <= 1'b1;
                        r_state <= S_DIV_DRV;
                    end
                end
                S_DIV_DRV: begin
                    if (r_go) begin
                        r_go <= 1'b0;
                    end else if (div_done) begin
                        r_drive      <= fsic_pkg::acc_sat(r_drive, r_pneg, div_ovf, div_quo);
                        r_last_count <= r_count;
                        // window test once per check period
                        if (n_chk >= CHK_END) begin
                            r_chk   <= '0;
                            r_ready <= (n_err_mag < {1'b0, r_err_win}) &&
                                       (n_slope_mag < {1'b0, r_slope_win});
                        end else begin
                            r_chk <= n_chk;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hold until the result register is free
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_drive <= r_drive;
                        r_out_speed <= r_est;
                        r_out_error <= r_err;
                        r_out_mode  <= r_ready;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.drive_action   = r_out_drive;
    assign o_out.filtered_speed = r_out_speed;
    assign o_out.speed_error    = r_out_error;
    assign o_out.ready_mode     = r_out_mode;

endmodule

// File: rtl/fsic_checker.sv
// Port-level assertions for the flywheel speed controller, bound to the top level.
`timescale 1ns / 1ps

module fsic_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_drive,
    input logic [31:0] i_speed,
    input logic [31:0] i_error,
    input logic        i_mode
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_drive) && $stable(i_speed) && $stable(i_error) && $stable(i_mode))
        else $error("result payload changed while stalled");

    // One item at a time: no transfer right after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while an item is in flight");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind flywheel_speed_integral_controller_core fsic_checker u_fsic_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_drive     (o_out.drive_action),
    .i_speed     (o_out.filtered_speed),
    .i_error     (o_out.speed_error),
    .i_mode      (o_out.ready_mode)
);

// File: tb/flywheel_speed_integral_controller_core_checker.sv
// Checker for the flywheel speed controller: tracks config, predicts and compares results.
`timescale 1ns / 1ps

module flywheel_speed_integral_controller_core_checker
    import fsic_pkg::*;
#(
    parameter int unsigned CHECK_PERIOD = 20,
    parameter int unsigned FRAC_BITS    = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    fsic_in_if                  i_in,
    fsic_out_if                 i_out,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic                i_pready,
    input  logic [ADDR_W-1:0]   i_paddr,
    input  logic [31:0]         i_pwdata,
    output int                  o_errors,
    output int                  o_pending
);

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic signed [31:0] drive;
        logic signed [31:0] speed;
        logic signed [31:0] err;
        logic               rdy;
    } speed_result_t;

    localparam wide_t S32_HI = 128'sd2147483647;
    localparam wide_t S32_LO = -128'sd2147483648;

    // Register copies
    logic signed [31:0] gain;
    logic [31:0]        gear;
    logic [15:0]        ticks;
    logic [23:0]        smooth;
    logic [30:0]        err_win;
    logic [30:0]        slope_win;

    // Controller state copies
    logic [31:0]        last_cnt;
    logic signed [31:0] est_speed;
    logic signed [31:0] slope;
    logic signed [31:0] err_val;
    logic signed [31:0] drive_acc;
    logic signed [31:0] target;
    logic               rdy_flag;
    int unsigned        check_cnt;

    speed_result_t result_queue[$];

    assign o_pending = result_queue.size();

    function automatic logic signed [31:0] clamp32(input wide_t v);
        if (v > S32_HI) return 32'sh7FFF_FFFF;
        if (v < S32_LO) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic wide_t abs_w(input wide_t v);
        return (v < 0) ? -v : v;
    endfunction

    // Advance the speed loop by one update item.
    task automatic apply_update(input logic [31:0] cnt, input logic [19:0] dt);
        logic signed [31:0] delta;
        wide_t d_w, dt_w, tpr_w, sm_w, mag, raw, diff, p, t;
        delta = cnt - last_cnt;
        d_w   = delta;
        dt_w  = {108'd0, dt};
        tpr_w = (ticks == 0) ? 128'sd1 : {112'd0, ticks};
        sm_w  = (smooth == 0) ? 128'sd1 : {104'd0, smooth};
        mag   = abs_w(d_w) * {96'd0, gear} * 128'sd1000000 / (tpr_w * dt_w);
        raw   = clamp32((d_w < 0) ? -mag : mag);
        diff  = raw - est_speed;
        last_cnt  = cnt;
        slope     = clamp32(diff * 128'sd1000000 / sm_w);
        est_speed = clamp32(est_speed + diff * dt_w / sm_w);
        err_val   = clamp32(est_speed - target);
        p = wide_t'(gain) * wide_t'(err_val);
        t = abs_w(p) * dt_w / (128'sd1000000 <<< FRAC_BITS);
        drive_acc = clamp32(drive_acc + ((p < 0) ? -t : t));
        check_cnt = (check_cnt + 1) & 10'h3FF;
        if (check_cnt >= CHECK_PERIOD) begin
            check_cnt = 0;
            rdy_flag = (abs_w(err_val) < {97'd0, err_win}) &&
                       (abs_w(slope) < {97'd0, slope_win});
        end
    endtask

    always @(posedge i_clk) begin
        speed_result_t exp_r;
        if (!i_rst_n) begin
            gain = 32'sd65536; gear = 32'd65536; ticks = TICKS_RESET;
            smooth = SMOOTH_RESET; err_win = 31'd65536; slope_win = 31'd65536;
            last_cnt = '0; est_speed = '0; slope = '0; err_val = '0;
            drive_acc = '0; target = '0; rdy_flag = 1'b1; check_cnt = 0;
            result_queue.delete();
            o_errors = 0;
        end else begin
            // Register write lands at the access edge
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    REG_GAIN:      gain = i_pwdata;
                    REG_GEAR:      gear = i_pwdata;
                    REG_TICKS:     ticks = i_pwdata[15:0];
                    REG_SMOOTH:    smooth = i_pwdata[23:0];
                    REG_ERR_WIN:   err_win = i_pwdata[30:0];
                    REG_SLOPE_WIN: slope_win = i_pwdata[30:0];
                    default: ;
                endcase
            end
            // Compare the result transfer against the oldest prediction
            if (i_out.valid && i_out.ready) begin
                if (result_queue.size() == 0) begin
                    $error("unexpected result transfer");
                    o_errors++;
                end else begin
                    exp_r = result_queue.pop_front();
                    if (i_out.drive_action !== exp_r.drive) begin
                        $error("drive_action: expected %0d, got %0d",
                               exp_r.drive, i_out.drive_action);
                        o_errors++;
                    end
                    if (i_out.filtered_speed !== exp_r.speed) begin
                        $error("filtered_speed: expected %0d, got %0d",
                               exp_r.speed, i_out.filtered_speed);
                        o_errors++;
                    end
                    if (i_out.speed_error !== exp_r.err) begin
                        $error("speed_error: expected %0d, got %0d",
                               exp_r.err, i_out.speed_error);
                        o_errors++;
                    end
                    if (i_out.ready_mode !== exp_r.rdy) begin
                        $error("ready_mode: expected %0d, got %0d",
                               exp_r.rdy, i_out.ready_mode);
                        o_errors++;
                    end
                end
            end
            // Predict on each accepted item
            if (i_in.valid && i_in.ready) begin
                if (i_in.command == CMD_SET) begin
                    target = i_in.target_speed;
                    rdy_flag = 1'b0;
                end else if (i_in.elapsed_us != 0) begin
                    apply_update(i_in.encoder_count, i_in.elapsed_us);
                end
                exp_r = '{drive: drive_acc, speed: est_speed, err: err_val, rdy: rdy_flag};
                result_queue.push_back(exp_r);
            end
        end
    end

endmodule

// File: tb/flywheel_speed_integral_controller_core_test.sv
// Testbench top for the flywheel speed controller: stimulus, config phases and verdict.
`timescale 1ns / 1ps

module flywheel_speed_integral_controller_core_test;
    import fsic_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int PHASE_ITEMS = 240;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // Config port, idle from time zero
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    fsic_in_if  in_ch();
    fsic_out_if out_ch();

    int errors;
    int pending;
    int cycle_count = 0;
    int items_sent = 0;
    int updates_sent = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_epoch = 0;
    logic [31:0] enc_pos = '0;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.command = CMD_UPDATE;
        in_ch.encoder_count = '0;
        in_ch.elapsed_us = '0;
        in_ch.target_speed = '0;
        out_ch.ready = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    flywheel_speed_integral_controller_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    flywheel_speed_integral_controller_core_checker checker_inst (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .i_out     (out_ch),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_pready  (pready),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_errors  (errors),
        .o_pending (pending)
    );

    // Watchdog: end the run if the block hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("flywheel_speed_integral_controller_core_test: done, errors");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off whenever hold_epoch advances,
    // so the block backs up and drops its input ready.
    always @(posedge i_clk) begin
        static int hold_left = 0;
        static int hold_seen = 0;
        if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left--;
        end else if (hold_seen != hold_epoch) begin
            hold_seen = hold_epoch;
            hold_left = 1500;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one item and hold it until the transfer.
    task automatic send_item(input logic cmd, input logic [31:0] cnt,
                             input logic [19:0] dt, input logic [31:0] tgt);
        if ($urandom_range(99) < sender_idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.command <= cmd;
        in_ch.encoder_count <= cnt;
        in_ch.elapsed_us <= dt;
        in_ch.target_speed <= tgt;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
        if (cmd == CMD_UPDATE) begin
            updates_sent++;
            enc_pos = cnt;
        end
    endtask

    // Hold the input until every predicted result has come back.
    task automatic drain();
        in_ch.valid <= 1'b0;
        // let the checker record the last transfer before reading its count
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // Register write: a setup phase, then an access phase.
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic load_config(input logic [31:0] g, input logic [31:0] gr,
                               input logic [31:0] tk, input logic [31:0] sm,
                               input logic [31:0] ew, input logic [31:0] sw);
        reg_write(REG_GAIN, g);
        reg_write(REG_GEAR, gr);
        reg_write(REG_TICKS, tk);
        reg_write(REG_SMOOTH, sm);
        reg_write(REG_ERR_WIN, ew);
        reg_write(REG_SLOPE_WIN, sw);
    endtask

    // Steady spin-up: target m rev/s, then updates whose count delta matches it
    // (360 ticks, unity gearing, 100 ms) so the loop settles and goes ready.
    task automatic steady_run();
        int m;
        int n;
        m = int'($urandom_range(0, 120)) - 60;
        send_item(CMD_SET, $urandom, 20'($urandom),
                  (m <<< 16) + int'($urandom_range(0, 80000)) - 40000);
        n = $urandom_range(20, 45);
        repeat (n) begin
            send_item(CMD_UPDATE, enc_pos + 36 * m + int'($urandom_range(0, 2)) - 1,
                      20'(32'd100000 + $urandom_range(0, 200) - 100), $urandom);
        end
    endtask

    // Unstructured items over the whole field ranges.
    task automatic noise_run();
        logic [19:0] dt;
        repeat ($urandom_range(3, 12)) begin
            case ($urandom_range(0, 5))
                0: dt = '0;
                1: dt = 20'hFFFFF;
                default: dt = 20'($urandom_range(1, 20'hFFFFF));
            endcase
            send_item(($urandom_range(0, 3) == 0) ? CMD_SET : CMD_UPDATE, $urandom, dt, $urandom);
        end
    endtask

    initial begin
        int phase_start;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero elapsed time, first update from zero, target extremes,
        // count wraparound and elapsed-time extremes.
        send_item(CMD_UPDATE, 32'd123, 20'd0, 32'd0);
        send_item(CMD_UPDATE, 32'd360, 20'd100000, 32'd0);
        send_item(CMD_SET, 32'd0, 20'd0, 32'd10 << 16);
        send_item(CMD_UPDATE, 32'd720, 20'd100000, 32'd0);
        send_item(CMD_UPDATE, 32'h8000_0000, 20'd1, 32'd0);
        send_item(CMD_UPDATE, 32'h7FFF_FFFF, 20'hFFFFF, 32'd0);
        send_item(CMD_SET, 32'd0, 20'd0, 32'h8000_0000);
        send_item(CMD_UPDATE, 32'h7FFF_FFFF, 20'd1, 32'd0);
        send_item(CMD_UPDATE, 32'h8000_0000, 20'd1, 32'd0);
        send_item(CMD_SET, 32'hFFFF_FFFF, 20'hFFFFF, 32'h7FFF_FFFF);
        send_item(CMD_UPDATE, 32'd0, 20'hFFFFF, 32'd0);
        send_item(CMD_UPDATE, 32'd5, 20'd0, 32'hFFFF_FFFF);

        for (int phase = 0; phase < 6; phase++) begin
            drain();
            case (phase)
                0: begin
                    sender_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    load_config(32'd262144, 32'd65536, 32'd360, 32'd100000,
                                32'd65536, 32'd131072);
                    sender_idle_pct = 47;
                    recv_stall_pct = 0;
                end
                2: begin
                    load_config(32'h8000_0000, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'd0, 32'd0);
                    sender_idle_pct = 0;
                    recv_stall_pct = 47;
                end
                3: begin
                    load_config(32'h7FFF_FFFF, 32'd1, 32'hFFFF, 32'hFF_FFFF,
                                32'h7FFF_FFFF, 32'h7FFF_FFFF);
                    sender_idle_pct = 14;
                    recv_stall_pct = 14;
                end
                4: begin
                    // zero ticks and smoothing behave as one
                    load_config($urandom, 32'd65536, 32'd0, 32'd0, 32'd300000, 32'd300000);
                    sender_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                default: begin
                    load_config($urandom_range(1, 32'h0010_0000), 32'd65536, 32'd360,
                                32'd100000, $urandom_range(1, 32'h0004_0000), 32'd65536);
                    sender_idle_pct = 47;
                    recv_stall_pct = 0;
                    hold_epoch++;
                end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) < 7) steady_run();
                else noise_run();
                if ($urandom_range(0, 9) == 0) drain();
            end
        end

        drain();
        repeat (500) @(posedge i_clk);
        $display("Sent %0d items (%0d updates) over six register settings,",
                 items_sent, updates_sent);
        $display("with input gaps, output stalls and one long output hold-off.");
        if (errors == 0 && pending == 0) begin
            $display("flywheel_speed_integral_controller_core_test: done, clean");
        end else begin
            $display("flywheel_speed_integral_controller_core_test: done, errors");
        end
        $finish;
    end

endmodule
